/* hw/rtl/i2da_pkg.sv */
package i2da_pkg;

  // operand bits actually converted (8 to 64)
  localparam int unsigned VALUE_BITS = 64;

  // fixed field widths of the channels
  localparam int unsigned ValueW = 64;
  localparam int unsigned PadW   = 5;
  localparam int unsigned CharW  = 8;

  // digit chain sizing
  localparam int unsigned MaxDigits = 20;
  localparam int unsigned IdxW      = $clog2(MaxDigits);
  localparam int unsigned CntW      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  // ascii codes
  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  // per-cycle control shared by every digit cell
  typedef struct packed {
    logic clr;
    logic shift;
  } i2da_cell_ctrl_t;

endpackage

/* hw/rtl/i2da_if.sv */
// input channel: one value to convert per transaction
interface i2da_in_if import i2da_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic              is_signed;
  logic [PadW-1:0]   pad_width;

  modport source (output valid, output value, output is_signed, output pad_width,
                  input ready);
  modport sink   (input valid, input value, input is_signed, input pad_width,
                  output ready);
endinterface

// output channel: one ascii character per transaction
interface i2da_out_if import i2da_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;
  logic             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

/* hw/rtl/i2da_digit_cell.sv */
module i2da_digit_cell import i2da_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2da_cell_ctrl_t ctrl_i,
  input  logic            bit_i,
  output logic            carry_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // add-3 correction ahead of the shift, msb moves to the next digit
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

/* hw/rtl/integer_to_decimal_ascii_top.sv */
// Binary to decimal ASCII converter.
// in_i takes one transaction per value: value, is_signed and pad_width.
// out_o gives the decimal text one character per transaction, most
// significant character first, with last set on the final character.
// A negative signed value starts with '-'; an unsigned value with nonzero
// pad_width gives exactly that many digits (zero filled or cut to the low
// digits), pad_width above 20 acts as 20.
// Conversion: after the accepting cycle the magnitude is shifted into a row of
// 20 BCD digit cells, one bit per cycle, then the leading digit is located,
// then the characters follow, one per cycle while the receiver takes them.
// The text is at most 20 characters long.
// in_i.ready is high only when no value is in progress; the final character
// may still wait in the output register while the next value is already
// being converted.
// A stall on out_o holds the current character and pauses emission.
// Reset clears the sequencer and the output valid; no transaction is
// pending afterwards and in_i.ready is already high during reset.
module integer_to_decimal_ascii_top import i2da_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2da_in_if.sink     in_i,
  i2da_out_if.source  out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StFind = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [PadW-1:0]       pad_q, pad_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  minus_q, minus_d;
  logic                  out_valid_q, out_valid_d;
  logic [CharW-1:0]      out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic                  in_take;
  logic                  out_load;
  logic [VALUE_BITS-1:0] in_bits;
  logic                  in_neg;
  i2da_cell_ctrl_t       cell_ctrl;
  logic [3:0]            digits [MaxDigits];
  logic                  carries [MaxDigits-1];
  logic [IdxW-1:0]       lead_idx;
  logic [3:0]            cur_digit;

  assign in_i.ready    = (state_q == StIdle);
  assign in_take       = in_i.valid && in_i.ready;
  assign out_load      = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last      = out_last_q;

  // operand masking and sign handling
  assign in_bits = in_i.value[VALUE_BITS-1:0];
  assign in_neg  = in_i.is_signed && in_bits[VALUE_BITS-1];

  // cell control
  assign cell_ctrl.clr   = in_take;
  assign cell_ctrl.shift = (state_q == StConv);

  // row of bcd digit cells, lowest digit takes the magnitude msb
  for (genvar g = 0; g < MaxDigits; g++) begin : g_digit
    if (g == 0) begin : g_first
      i2da_digit_cell u_digit (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .bit_i   (mag_q[VALUE_BITS-1]),
        .carry_o (carries[g]),
        .digit_o (digits[g])
      );
    end else if (g == MaxDigits - 1) begin : g_top
      i2da_digit_cell u_digit (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .bit_i   (carries[g-1]),
        .carry_o (),
        .digit_o (digits[g])
      );
    end else begin : g_mid
      i2da_digit_cell u_digit (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (cell_ctrl),
        .bit_i   (carries[g-1]),
        .carry_o (carries[g]),
        .digit_o (digits[g])
      );
    end
  end

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (digits[i] != 4'd0) begin
        lead_idx = IdxW'(i);
      end
    end
  end

  assign cur_digit = digits[idx_q];

  // sequencer and output register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    pad_d       = pad_q;
    idx_d       = idx_q;
    minus_d     = minus_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (out_load) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_take) begin
          mag_d   = in_neg ? (~in_bits + VALUE_BITS'(1)) : in_bits;
          neg_d   = in_neg;
          if (in_i.is_signed) begin
            pad_d = '0;
          end else if (in_i.pad_width > PadW'(MaxDigits)) begin
            pad_d = PadW'(MaxDigits);
          end else begin
            pad_d = in_i.pad_width;
          end
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(VALUE_BITS - 1)) begin
          state_d = StFind;
        end
      end
      StFind: begin
        if (pad_q != '0) begin
          idx_d = IdxW'(pad_q - PadW'(1));
        end else begin
          idx_d = lead_idx;
        end
        minus_d = neg_q;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (minus_q) begin
            out_char_d = CharMinus;
            out_last_d = 1'b0;
            minus_d    = 1'b0;
          end else begin
            out_char_d = CharZero + {4'd0, cur_digit};
            out_last_d = (idx_q == '0);
            if (idx_q == '0) begin
              state_d = StIdle;
            end else begin
              idx_d = idx_q - IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      minus_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      minus_q     <= minus_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    pad_q      <= pad_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench import i2da_pkg::*;;

  localparam int unsigned DirectedLen = 21;
  localparam int unsigned RandomReqs  = 90;
  localparam int unsigned LongHold    = 600;
  localparam int unsigned DrainCycles = VALUE_BITS + 40;
  localparam int unsigned CycleLimit  = 400000;

  // one conversion request as offered on the input channel
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              is_signed;
    logic [PadW-1:0]   pad_width;
  } conv_req_t;

  // one character of the decimal text
  typedef struct packed {
    logic [CharW-1:0] character;
    logic             last;
  } text_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2da_in_if  in_if ();
  i2da_out_if out_if ();

  conv_req_t   pending_reqs[$];
  text_char_t  expected_chars[$];
  conv_req_t   next_req;
  text_char_t  want_char;
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned total_reqs = 0;

  int unsigned send_gap;
  int unsigned send_left = 0;
  bit          send_quiet = 1'b0;
  int unsigned recv_wait;
  int unsigned recv_left = 0;
  bit          recv_quiet = 1'b0;
  int unsigned recv_hold;
  int unsigned chars_seen;

  integer_to_decimal_ascii_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // wait before the next transaction, in stretches that either run flat out or draw random waits
  function automatic int unsigned draw_wait(inout int unsigned left, inout bit quiet);
    if (left == 0) begin
      left  = $urandom_range(4, 24);
      quiet = ($urandom_range(0, 2) == 0);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void add_req(logic [ValueW-1:0] value, logic is_signed,
                                  logic [PadW-1:0] pad_width);
    conv_req_t req;
    req.value     = value;
    req.is_signed = is_signed;
    req.pad_width = pad_width;
    pending_reqs.push_back(req);
  endfunction

  // expected decimal text of one request, pushed one character at a time
  function automatic void predict_text(conv_req_t req);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] mask;
    logic [CharW-1:0]  digits[MaxDigits];
    text_char_t        ch;
    bit                neg;
    int unsigned       pad;
    int unsigned       nd;
    int unsigned       pos;

    mask = (VALUE_BITS >= 64) ? '1 : ((ValueW'(1) << VALUE_BITS) - ValueW'(1));
    mag  = req.value & mask;
    pad  = req.pad_width;
    neg  = 1'b0;
    nd   = 0;

    // signed: take the full magnitude, padding does not apply
    if (req.is_signed) begin
      if (mag[VALUE_BITS-1]) begin
        neg = 1'b1;
        mag = (~mag + ValueW'(1)) & mask;
      end
      pad = 0;
    end
    if (pad > MaxDigits) pad = MaxDigits;

    // digits least significant first
    do begin
      digits[nd] = CharZero + CharW'(mag % ValueW'(10));
      mag = mag / ValueW'(10);
      nd++;
    end while (mag != 0 && nd < MaxDigits);

    if (neg) begin
      ch.character = CharMinus;
      ch.last      = 1'b0;
      expected_chars.push_back(ch);
    end
    if (pad != 0) begin
      for (int i = 0; i < pad; i++) begin
        pos          = pad - 1 - i;
        ch.character = (pos < nd) ? digits[pos] : CharZero;
        ch.last      = (i == pad - 1);
        expected_chars.push_back(ch);
      end
    end else begin
      for (int i = 0; i < nd; i++) begin
        ch.character = digits[nd - 1 - i];
        ch.last      = (i == nd - 1);
        expected_chars.push_back(ch);
      end
    end
  endfunction

  // driver: offers queued requests, predicts each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.value     <= '0;
      in_if.is_signed <= 1'b0;
      in_if.pad_width <= '0;
      send_gap        <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        next_req.value     = in_if.value;
        next_req.is_signed = in_if.is_signed;
        next_req.pad_width = in_if.pad_width;
        predict_text(next_req);
        sent_count++;
      end
      // channel free after this edge
      if (!in_if.valid || in_if.ready) begin
        if (send_gap != 0) begin
          send_gap    <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req         = pending_reqs.pop_front();
          in_if.value     <= next_req.value;
          in_if.is_signed <= next_req.is_signed;
          in_if.pad_width <= next_req.pad_width;
          in_if.valid     <= 1'b1;
          send_gap        <= draw_wait(send_left, send_quiet);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each character transaction and paces out_if.ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_wait    <= 0;
      chars_seen   <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character %h last %b", $time,
                   out_if.character, out_if.last);
          fail_count++;
        end else begin
          want_char = expected_chars.pop_front();
          if (out_if.character !== want_char.character) begin
            $display("%0t: character mismatch, expected %h got %h", $time,
                     want_char.character, out_if.character);
            fail_count++;
          end
          if (out_if.last !== want_char.last) begin
            $display("%0t: last mismatch, expected %b got %b", $time,
                     want_char.last, out_if.last);
            fail_count++;
          end
        end
        chars_seen <= chars_seen + 1;
        // long hold-off twice in the run so the converter backs up into in_if
        if (chars_seen == 60 || chars_seen == 700) recv_hold = LongHold;
        else recv_hold = draw_wait(recv_left, recv_quiet);
        recv_wait    <= recv_hold;
        out_if.ready <= (recv_hold == 0);
      end else if (!out_if.ready) begin
        if (recv_wait <= 1) out_if.ready <= 1'b1;
        recv_wait <= (recv_wait == 0) ? 0 : recv_wait - 1;
      end
    end
  end

  // timeout
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("testbench: FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin
    logic [ValueW-1:0] raw;
    int unsigned       width_pick;
    logic              sign_pick;
    logic [PadW-1:0]   pad_pick;

    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.value     = '0;
    in_if.is_signed = 1'b0;
    in_if.pad_width = '0;
    out_if.ready    = 1'b0;

    // directed: zero, extremes, padding cut and fill, saturated pad, signed corners
    add_req('0, 1'b0, '0);
    add_req('0, 1'b0, PadW'(7));
    add_req(ValueW'(1), 1'b0, '0);
    add_req(ValueW'(9), 1'b0, '0);
    add_req(ValueW'(10), 1'b0, '0);
    add_req('1, 1'b0, '0);
    add_req('1, 1'b0, PadW'(MaxDigits));
    add_req('1, 1'b0, '1);
    add_req('1, 1'b0, PadW'(3));
    add_req('1, 1'b0, PadW'(19));
    add_req(ValueW'(123), 1'b0, PadW'(1));
    add_req(ValueW'(12345), 1'b0, PadW'(10));
    add_req(ValueW'(42), 1'b0, PadW'(MaxDigits));
    add_req(64'd10000000000000000000, 1'b0, '0);
    add_req(64'd9999999999999999999, 1'b0, '0);
    add_req('1, 1'b1, '0);
    add_req({1'b1, {(ValueW-1){1'b0}}}, 1'b1, '0);
    add_req({1'b1, {(ValueW-2){1'b0}}, 1'b1}, 1'b1, '0);
    add_req({1'b0, {(ValueW-1){1'b1}}}, 1'b1, PadW'(5));
    add_req('0, 1'b1, '1);
    add_req(-ValueW'(10), 1'b1, PadW'(12));
    if (pending_reqs.size() != DirectedLen) $display("directed list size %0d",
                                                     pending_reqs.size());

    // random: magnitudes of every length, both signs, mixed padding
    for (int n = 0; n < RandomReqs; n++) begin
      width_pick = $urandom_range(1, ValueW);
      raw        = {$urandom, $urandom};
      if (width_pick < ValueW) raw = raw & ((ValueW'(1) << width_pick) - ValueW'(1));
      sign_pick  = $urandom_range(0, 1);
      if (sign_pick && $urandom_range(0, 1)) raw = -raw;
      pad_pick   = $urandom_range(0, 1) ? PadW'(0) : PadW'($urandom_range(1, 31));
      add_req(raw, sign_pick, pad_pick);
    end
    total_reqs = pending_reqs.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every request accepted and predicted, then every character seen
    while (sent_count != total_reqs) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
